// ===== rtl/f16_pkg.sv =====
// Shared types and constants for the FAT16 offset resolver.
package f16_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int DIV_STEPS = 32;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [15:0] ENT_END  = 16'hFFF8;
  localparam logic [15:0] ENT_BAD  = 16'hFFF7;
  localparam logic [15:0] ENT_RESV = 16'hFFF0;
  localparam logic [15:0] ENT_FREE = 16'h0000;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;
  localparam logic [19:0] CHUNK_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    REG_SECT_BYTES   = 2'd0,
    REG_CLUSTER_SECT = 2'd1,
    REG_DATA_START   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_END   = 3'd1,
    ST_BAD   = 3'd2,
    ST_RESV  = 3'd3,
    ST_FREE  = 3'd4,
    ST_RANGE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_WADDR,
    S_WDATA,
    S_SECT,
    S_POS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    walk_init;
    logic    walk_adv;
    logic    fail;
    status_t fail_code;
    logic    sect_calc;
    logic    pos_calc;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic    is_resolve;
    logic    div_done;
    logic    links_zero;
    logic    cur_range;
    status_t entry_code;
    logic    out_busy;
  } stat_t;

  // Classify a table entry read during the walk.
  function automatic status_t check_entry(input logic [15:0] e);
    status_t r;
    if (e >= ENT_END) r = ST_END;
    else if (e == ENT_BAD) r = ST_BAD;
    else if (e >= ENT_RESV) r = ST_RESV;
    else if (e == ENT_FREE) r = ST_FREE;
    else r = ST_OK;
    return r;
  endfunction

endpackage

// ===== rtl/fat16_offset_to_disk_position.sv =====
// A resolve runs the offset divider, then one table read per chain link, then the sector
// and position steps; one resolve in flight at a time, the next accepted once it is done.
// Table writes are accepted back to back; a resolve is accepted while a result waits.
// Synchronous reset clears control and configuration (512, 4, 0);
// the table is undefined until written.
module fat16_offset_to_disk_position (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [15:0] cluster_index,
  input  logic [15:0] entry_value,
  input  logic [31:0] byte_offset,
  input  logic [31:0] request_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] found_cluster,
  output logic [31:0] abs_sector,
  output logic [31:0] abs_position,
  output logic [19:0] chunk_length,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  f16_pkg::cmd_t  cmd;
  f16_pkg::stat_t st;

  // Sequence each beat
  f16_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .st(st), .cmd(cmd)
  );

  // Compute the result
  f16_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mode(mode), .cluster_index(cluster_index), .entry_value(entry_value),
    .byte_offset(byte_offset), .request_length(request_length),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .found_cluster(found_cluster), .abs_sector(abs_sector),
    .abs_position(abs_position), .chunk_length(chunk_length)
  );

endmodule

// ===== rtl/f16_ctrl.sv =====
// Sequencer for the FAT16 resolver: take table writes, or divide, walk the chain, compute positions.
module f16_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  f16_pkg::stat_t st,
  output f16_pkg::cmd_t  cmd
);

  f16_pkg::state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= f16_pkg::S_IDLE;
    else state <= state_next;
  end

  // Decode next state and datapath commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.fail_code = f16_pkg::ST_OK;
    in_ready = 1'b0;
    case (state)
      f16_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.is_resolve) state_next = f16_pkg::S_DIV;
        end
      end
      f16_pkg::S_DIV: begin
        if (st.div_done) begin
          cmd.walk_init = 1'b1;
          state_next = f16_pkg::S_WADDR;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      f16_pkg::S_WADDR: begin
        if (st.links_zero) begin
          state_next = f16_pkg::S_SECT;
        end else if (st.cur_range) begin
          cmd.fail = 1'b1;
          cmd.fail_code = f16_pkg::ST_RANGE;
          state_next = f16_pkg::S_DONE;
        end else begin
          state_next = f16_pkg::S_WDATA;
        end
      end
      f16_pkg::S_WDATA: begin
        if (st.entry_code != f16_pkg::ST_OK) begin
          cmd.fail = 1'b1;
          cmd.fail_code = st.entry_code;
          state_next = f16_pkg::S_DONE;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next = f16_pkg::S_WADDR;
        end
      end
      f16_pkg::S_SECT: begin
        cmd.sect_calc = 1'b1;
        state_next = f16_pkg::S_POS;
      end
      f16_pkg::S_POS: begin
        cmd.pos_calc = 1'b1;
        state_next = f16_pkg::S_DONE;
      end
      f16_pkg::S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = f16_pkg::S_IDLE;
        end
      end
      default: state_next = f16_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/f16_dp.sv =====
// Datapath: table memory, offset divider, chain walker, position math, output register.
module f16_dp (
  input  logic           clk,
  input  logic           rst,
  input  f16_pkg::cmd_t  cmd,
  output f16_pkg::stat_t st,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           mode,
  input  logic [15:0]    cluster_index,
  input  logic [15:0]    entry_value,
  input  logic [31:0]    byte_offset,
  input  logic [31:0]    request_length,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     status,
  output logic [15:0]    found_cluster,
  output logic [31:0]    abs_sector,
  output logic [31:0]    abs_position,
  output logic [19:0]    chunk_length
);

  logic [12:0] sec_bytes;
  logic [7:0]  cluster_sect;
  logic [31:0] data_start;

  logic [15:0] mem [f16_pkg::TABLE_ENTRIES];
  logic [15:0] rd;

  logic [31:0] req;
  logic [20:0] rem;
  logic [31:0] quot;
  logic [f16_pkg::CNT_W-1:0] cnt;
  logic [20:0] cbytes;
  logic        cz;
  logic [21:0] rem_sh;
  logic [31:0] links;
  logic [20:0] in_clus;
  logic [15:0] cur;
  logic [31:0] sector;
  logic [31:0] pos;
  logic [19:0] chunk;
  f16_pkg::status_t sts;
  logic [20:0] left;
  logic [31:0] pick;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_bytes <= 13'd512;
      cluster_sect <= 8'd4;
      data_start <= 32'd0;
    end else if (cfg_we) begin
      case (f16_pkg::reg_idx_t'(cfg_index))
        f16_pkg::REG_SECT_BYTES:   sec_bytes <= cfg_data[12:0];
        f16_pkg::REG_CLUSTER_SECT: cluster_sect <= cfg_data[7:0];
        f16_pkg::REG_DATA_START:   data_start <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cbytes = 21'(sec_bytes * cluster_sect);
  assign cz = (cbytes == 21'd0);

  // Store in-range table entries on write beats, read at the current cluster each cycle
  always_ff @(posedge clk) begin
    if (cmd.load && !mode && (32'(cluster_index) < 32'(f16_pkg::TABLE_ENTRIES)))
      mem[cluster_index[f16_pkg::ADDR_W-1:0]] <= entry_value;
    rd <= mem[cur[f16_pkg::ADDR_W-1:0]];
  end

  // Restoring divide of the offset by the cluster size, one quotient bit a cycle
  assign rem_sh = {rem, quot[31]};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= '0;
      quot <= byte_offset;
      cnt <= '0;
      req <= request_length;
    end else if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (rem_sh >= {1'b0, cbytes}) begin
        rem <= 21'(rem_sh - {1'b0, cbytes});
        quot <= {quot[30:0], 1'b1};
      end else begin
        rem <= rem_sh[20:0];
        quot <= {quot[30:0], 1'b0};
      end
    end
  end

  // Walk the chain one link per read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= cluster_index;
      sts <= f16_pkg::ST_OK;
    end else if (cmd.walk_init) begin
      links <= cz ? 32'd0 : quot;
      in_clus <= cz ? 21'd0 : rem;
    end else if (cmd.walk_adv) begin
      cur <= rd;
      links <= links - 32'd1;
    end else if (cmd.fail) begin
      sts <= cmd.fail_code;
    end
  end

  // Cluster start sector, then byte position and chunk
  assign left = cbytes - in_clus;
  assign pick = (req < {11'd0, left}) ? req : {11'd0, left};
  always_ff @(posedge clk) begin
    if (cmd.sect_calc)
      sector <= data_start + 32'(({16'd0, cur} - f16_pkg::FIRST_DATA_CLUSTER) * cluster_sect);
    if (cmd.pos_calc) begin
      pos <= 32'(sector * sec_bytes) + {11'd0, in_clus};
      chunk <= (pick > {12'd0, f16_pkg::CHUNK_MAX}) ? f16_pkg::CHUNK_MAX : pick[19:0];
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= sts;
      if (sts == f16_pkg::ST_OK) begin
        found_cluster <= cur;
        abs_sector <= sector;
        abs_position <= pos;
        chunk_length <= chunk;
      end else begin
        found_cluster <= '0;
        abs_sector <= '0;
        abs_position <= '0;
        chunk_length <= '0;
      end
    end
  end

  assign st.is_resolve = mode;
  assign st.div_done = (cnt == f16_pkg::CNT_W'(f16_pkg::DIV_STEPS));
  assign st.links_zero = (links == 32'd0);
  assign st.cur_range = (32'(cur) >= 32'(f16_pkg::TABLE_ENTRIES));
  assign st.entry_code = f16_pkg::check_entry(rd);
  assign st.out_busy = out_valid && !out_ready;

endmodule
